// ----- hw/rtl/bdmv_pkg.sv -----
// bdmv_pkg: shared constants, types and helper functions for the
// block-diagonal matrix-vector core. No dependencies.
`default_nettype none
package bdmv_pkg;
	localparam int MAX_ATOMS    = 16;
	localparam int MAX_ROW      = 64;
	localparam int MATRIX_WORDS = 1024;
	localparam int MAX_BLOCK    = 16;

	localparam int ATOM_W  = $clog2(MAX_ATOMS);
	localparam int ROW_W   = $clog2(MAX_ROW);
	localparam int LEN_W   = 7;
	localparam int NA_W    = 5;
	localparam int BS_W    = 5;
	localparam int IDX_W   = 10;
	localparam int MADDR_W = $clog2(MATRIX_WORDS);
	localparam int DATA_W  = 32;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int ACC_W   = PROD_W + 6;
	localparam int BASE_W  = $clog2(MAX_ATOMS * MAX_BLOCK * MAX_BLOCK + MAX_BLOCK * MAX_BLOCK) + 1;
	localparam int CFG_W   = 7;

	localparam logic [1:0] CMD_BSIZE = 2'd0;
	localparam logic [1:0] CMD_MAT   = 2'd1;
	localparam logic [1:0] CMD_PUSH  = 2'd2;

	localparam logic [1:0] REG_NUM_ATOMS = 2'd0;
	localparam logic [1:0] REG_ROW_LEN   = 2'd1;
	localparam logic [1:0] REG_COMPLEX   = 2'd2;

	typedef enum logic [1:0] {OP_BSIZE, OP_MAT, OP_PUSH, OP_PUSH_LAST} op_t;

	typedef struct packed {
		op_t                op;
		logic [IDX_W-1:0]   addr;
		logic [BS_W-1:0]    bs;
		logic [DATA_W-1:0]  re;
		logic [DATA_W-1:0]  im;
	} entry_t;

	typedef struct packed {
		logic [NA_W-1:0]  num_atoms;
		logic [LEN_W-1:0] row_length;
		logic             complex_mode;
	} cfg_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
		logic [LEN_W-1:0] r;
		if (l == '0) r = LEN_W'(1);
		else if (32'(l) > MAX_ROW) r = LEN_W'(MAX_ROW);
		else r = l;
		return r;
	endfunction

	function automatic logic [NA_W-1:0] eff_atoms(input logic [NA_W-1:0] n);
		logic [NA_W-1:0] r;
		if (32'(n) > MAX_ATOMS) r = NA_W'(MAX_ATOMS);
		else r = n;
		return r;
	endfunction

	// floor shift by 16 and saturate to 32 bits
	function automatic logic [DATA_W-1:0] sat_out(input logic [ACC_W-1:0] acc);
		logic fits;
		logic [DATA_W-1:0] r;
		fits = (&acc[ACC_W-1:47]) | ~(|acc[ACC_W-1:47]);
		if (fits) r = acc[47:16];
		else if (acc[ACC_W-1]) r = 32'h8000_0000;
		else r = 32'h7FFF_FFFF;
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/bdmv_ifs.sv -----
// bdmv_item_if and bdmv_result_if: valid/ready channels of the core.
// Depends on bdmv_pkg.
`default_nettype none
interface bdmv_item_if import bdmv_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic [IDX_W-1:0]         index;
	logic [BS_W-1:0]          block_size;
	logic signed [DATA_W-1:0] table_word;
	logic signed [DATA_W-1:0] elem_re;
	logic signed [DATA_W-1:0] elem_im;
	modport source(output valid, cmd, index, block_size, table_word, elem_re, elem_im,
		input ready);
	modport sink(input valid, cmd, index, block_size, table_word, elem_re, elem_im,
		output ready);
endinterface

interface bdmv_result_if import bdmv_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] out_re;
	logic signed [DATA_W-1:0] out_im;
	logic [ROW_W-1:0]         out_pos;
	logic                     last;
	modport source(output valid, out_re, out_im, out_pos, last, input ready);
	modport sink(input valid, out_re, out_im, out_pos, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/block_diagonal_matvec_core.sv -----
// block_diagonal_matvec_core: top level with configuration registers,
// front, queue and back. Depends on bdmv_pkg, bdmv_ifs and the bdmv modules.
//
// usage:
// items channel carries commands: block size write, matrix word write and
// vector element push; results channel returns one transaction per row
// position (out_re, out_im, out_pos, last) once a row is complete.
// config is written through cfg_we / cfg_index / cfg_data; the user must
// do so only while idle, the block itself does not enforce it.
// front takes a transaction per cycle while the two-entry queue has room;
// writes retire in the back at one per cycle while the back is idle.
// after the last element of a row the back walks the blocks: each output
// of an atom of size n is a multiply-accumulate of n products on one
// shared multiplier pair, followed by pipeline drain and emit; positions
// not covered by a block are emitted as zero after the blocks.
// while the back computes, the front fills the queue and then stalls.
// a stalled receiver holds the output register; the sequencer waits at
// its next emit. reset clears config (row length to 1), block sizes, row
// fill and all control; matrix and row buffer stay undefined until written.
`default_nettype none
module block_diagonal_matvec_core import bdmv_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [1:0]         cfg_index,
	input  wire [CFG_W-1:0]   cfg_data,
	bdmv_item_if.sink         items,
	bdmv_result_if.source     results
);
	cfg_t   cfg_q;
	logic   push;
	logic   full;
	logic   q_valid;
	logic   q_pop;
	entry_t wentry;
	entry_t rentry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_atoms    <= '0;
			cfg_q.row_length   <= LEN_W'(1);
			cfg_q.complex_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ATOMS: cfg_q.num_atoms    <= cfg_data[NA_W-1:0];
				REG_ROW_LEN:   cfg_q.row_length   <= cfg_data[LEN_W-1:0];
				REG_COMPLEX:   cfg_q.complex_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bdmv_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .items(items),
		.q_full(full), .push(push), .entry(wentry)
	);

	bdmv_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wentry), .full(full),
		.pop(q_pop), .valid(q_valid), .rdata(rentry)
	);

	bdmv_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid),
		.q_data(rentry), .q_pop(q_pop), .results(results)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/bdmv_front.sv -----
// bdmv_front: accepts items, drops no-op commands, tracks row fill and
// tags the last element of a row. Depends on bdmv_pkg and bdmv_ifs.
`default_nettype none
module bdmv_front import bdmv_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  cfg_t         cfg,
	bdmv_item_if.sink    items,
	input  wire          q_full,
	output logic         push,
	output entry_t       entry
);
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] slot;
	logic             take;
	logic             row_end;

	assign len     = eff_len(cfg.row_length);
	assign items.ready = !q_full;
	assign take    = items.valid && items.ready;
	// row length may have been lowered, restart the row then
	assign slot    = (fill_q >= len) ? '0 : fill_q;
	assign row_end = (slot + LEN_W'(1)) >= len;

	always_comb begin
		push = 1'b0;
		entry.op = OP_PUSH;
		entry.addr = items.index;
		entry.bs = (32'(items.block_size) > MAX_BLOCK) ? BS_W'(MAX_BLOCK) : items.block_size;
		entry.re = items.elem_re;
		entry.im = items.elem_im;
		unique case (items.cmd)
			CMD_BSIZE: begin
				entry.op = OP_BSIZE;
				push = take && (32'(items.index) < MAX_ATOMS);
			end
			CMD_MAT: begin
				entry.op = OP_MAT;
				entry.re = items.table_word;
				push = take && (32'(items.index) < MATRIX_WORDS);
			end
			CMD_PUSH: begin
				entry.op = row_end ? OP_PUSH_LAST : OP_PUSH;
				entry.addr = IDX_W'(slot);
				push = take;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take && items.cmd == CMD_PUSH) begin
			fill_q <= row_end ? '0 : slot + LEN_W'(1);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/bdmv_queue.sv -----
// bdmv_queue: two-entry queue between front and back.
// Depends on bdmv_pkg.
`default_nettype none
module bdmv_queue import bdmv_pkg::*; (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push,
	input  entry_t wdata,
	output logic   full,
	input  wire    pop,
	output logic   valid,
	output entry_t rdata
);
	entry_t     mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/bdmv_back.sv -----
// bdmv_back: holds block sizes, matrix and row buffer, executes queued
// transactions and runs the per-row multiply-accumulate sequence.
// Depends on bdmv_pkg and bdmv_ifs.
`default_nettype none
module bdmv_back import bdmv_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  cfg_t           cfg,
	input  wire            q_valid,
	input  entry_t         q_data,
	output logic           q_pop,
	bdmv_result_if.source  results
);
	typedef enum logic [2:0] {S_IDLE, S_ATOM, S_COL, S_MAC, S_DRAIN, S_EMIT, S_ZERO} state_t;

	state_t              state_q;
	logic [BS_W-1:0]     bs_q [MAX_ATOMS];
	logic [DATA_W-1:0]   mat_mem [MATRIX_WORDS];
	logic [DATA_W-1:0]   rb_re_mem [MAX_ROW];
	logic [DATA_W-1:0]   rb_im_mem [MAX_ROW];

	logic [NA_W-1:0]     a_q;
	logic [LEN_W-1:0]    pos_q;
	logic [LEN_W-1:0]    start_q;
	logic [BS_W-1:0]     n_q;
	logic [BS_W-1:0]     i_q;
	logic [BS_W-1:0]     j_q;
	logic [BASE_W-1:0]   base_q;
	logic [BASE_W-1:0]   addr_q;
	logic [ACC_W-1:0]    acc_re_q;
	logic [ACC_W-1:0]    acc_im_q;

	logic signed [DATA_W-1:0] mat_s1, re_s1, im_s1;
	logic                     busy_s1, vld_s1;
	logic signed [PROD_W-1:0] prod_re_s2, prod_im_s2;
	logic                     busy_s2, vld_s2;

	logic                out_valid_q;
	logic [DATA_W-1:0]   out_re_q, out_im_q;
	logic [ROW_W-1:0]    out_pos_q;
	logic                out_last_q;

	logic [LEN_W-1:0]    len;
	logic [NA_W-1:0]     atoms;
	logic [LEN_W-1:0]    vp;
	logic [LEN_W-1:0]    cur_p;
	logic                issue;
	logic                rd_ok;
	logic                slot_free;
	logic                emit_now;
	logic [BS_W-1:0]     n_cur;

	assign len       = eff_len(cfg.row_length);
	assign atoms     = eff_atoms(cfg.num_atoms);
	assign vp        = start_q + LEN_W'(j_q);
	assign cur_p     = start_q + LEN_W'(i_q);
	assign issue     = state_q == S_MAC;
	assign rd_ok     = (vp < len) && (32'(addr_q) < MATRIX_WORDS);
	assign slot_free = !out_valid_q || results.ready;
	assign emit_now  = slot_free && (state_q == S_EMIT || state_q == S_ZERO);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign n_cur     = bs_q[a_q[ATOM_W-1:0]];

	assign results.valid   = out_valid_q;
	assign results.out_re  = out_re_q;
	assign results.out_im  = out_im_q;
	assign results.out_pos = out_pos_q;
	assign results.last    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ATOMS; k++) bs_q[k] <= '0;
		end else if (q_pop && q_data.op == OP_BSIZE) begin
			bs_q[q_data.addr[ATOM_W-1:0]] <= q_data.bs;
		end
	end

	// memories: one write port each, registered reads
	always_ff @(posedge clk) begin
		if (q_pop && q_data.op == OP_MAT) mat_mem[q_data.addr[MADDR_W-1:0]] <= q_data.re;
		if (q_pop && (q_data.op == OP_PUSH || q_data.op == OP_PUSH_LAST)) begin
			rb_re_mem[q_data.addr[ROW_W-1:0]] <= q_data.re;
			rb_im_mem[q_data.addr[ROW_W-1:0]] <= q_data.im;
		end
		mat_s1 <= mat_mem[addr_q[MADDR_W-1:0]];
		re_s1  <= rb_re_mem[vp[ROW_W-1:0]];
		im_s1  <= rb_im_mem[vp[ROW_W-1:0]];
		prod_re_s2 <= re_s1 * mat_s1;
		prod_im_s2 <= im_s1 * mat_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			vld_s1  <= 1'b0;
			busy_s2 <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			busy_s1 <= issue;
			vld_s1  <= issue && rd_ok;
			busy_s2 <= busy_s1;
			vld_s2  <= vld_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			a_q         <= '0;
			pos_q       <= '0;
			start_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			base_q      <= '0;
			addr_q      <= '0;
			acc_re_q    <= '0;
			acc_im_q    <= '0;
			out_valid_q <= 1'b0;
			out_re_q    <= '0;
			out_im_q    <= '0;
			out_pos_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (results.ready && !emit_now) out_valid_q <= 1'b0;
			if (state_q == S_COL) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else if (vld_s2) begin
				acc_re_q <= acc_re_q + {{(ACC_W-PROD_W){prod_re_s2[PROD_W-1]}}, prod_re_s2};
				acc_im_q <= acc_im_q + {{(ACC_W-PROD_W){prod_im_s2[PROD_W-1]}}, prod_im_s2};
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && q_data.op == OP_PUSH_LAST) begin
						a_q     <= '0;
						pos_q   <= '0;
						base_q  <= '0;
						state_q <= S_ATOM;
					end
				end
				S_ATOM: begin
					if (pos_q >= len) begin
						state_q <= S_IDLE;
					end else if (a_q >= atoms) begin
						state_q <= S_ZERO;
					end else if (n_cur == '0) begin
						a_q <= a_q + NA_W'(1);
					end else begin
						n_q     <= n_cur;
						start_q <= pos_q;
						i_q     <= '0;
						state_q <= S_COL;
					end
				end
				S_COL: begin
					if (i_q == n_q || cur_p >= len) begin
						pos_q   <= start_q + LEN_W'(n_q);
						base_q  <= base_q + BASE_W'(n_q) * BASE_W'(n_q);
						a_q     <= a_q + NA_W'(1);
						state_q <= S_ATOM;
					end else begin
						j_q     <= '0;
						addr_q  <= base_q + BASE_W'(i_q);
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					addr_q <= addr_q + BASE_W'(n_q);
					j_q    <= j_q + BS_W'(1);
					if (j_q == n_q - BS_W'(1)) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!busy_s1 && !busy_s2) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_re_q    <= sat_out(acc_re_q);
						out_im_q    <= cfg.complex_mode ? sat_out(acc_im_q) : '0;
						out_pos_q   <= cur_p[ROW_W-1:0];
						out_last_q  <= (cur_p + LEN_W'(1)) == len;
						i_q         <= i_q + BS_W'(1);
						state_q     <= S_COL;
					end
				end
				S_ZERO: begin
					// positions past the last block read as zero
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_re_q    <= '0;
						out_im_q    <= '0;
						out_pos_q   <= pos_q[ROW_W-1:0];
						out_last_q  <= (pos_q + LEN_W'(1)) == len;
						pos_q       <= pos_q + LEN_W'(1);
						if ((pos_q + LEN_W'(1)) == len) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/bdmv_checker.sv -----
// bdmv_checker: port-level assertions on the result channel, bound to
// block_diagonal_matvec_core. Depends on bdmv_pkg.
`default_nettype none
module bdmv_checker import bdmv_pkg::*; (
	input wire               clk,
	input wire               arst_n,
	input wire               res_valid,
	input wire               res_ready,
	input wire [DATA_W-1:0]  res_re,
	input wire [DATA_W-1:0]  res_im,
	input wire [ROW_W-1:0]   res_pos,
	input wire               res_last
);
	// a row never runs past position 63 without ending
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_pos == 6'd63) |-> res_last)
		else $error("row ran past last position");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_re) && $stable(res_im)
		&& $stable(res_pos) && $stable(res_last))
		else $error("stalled result changed");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid during reset");

	// a non-final result is followed by the next position
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last ##1 res_valid |->
		res_pos == $past(res_pos) + 6'd1)
		else $error("result position skipped");
endmodule

bind block_diagonal_matvec_core bdmv_checker u_bdmv_checker (
	.clk(clk), .arst_n(arst_n), .res_valid(results.valid), .res_ready(results.ready),
	.res_re(results.out_re), .res_im(results.out_im), .res_pos(results.out_pos),
	.res_last(results.last)
);
`default_nettype wire
